@@ sv/bba_pkg.sv @@
package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int LEVELS     = 13;
  localparam int CNT_W      = 13;
  localparam int IDX_W      = 12;
  localparam int LVL_W      = 4;
  localparam int MAP_AW     = 13;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SEL   = 6;
  localparam int WORD_AW    = 7;
  localparam int WORD_DEPTH = 128;
  localparam int MIN_SHIFT  = 10;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int USED_W     = 23;
  localparam int STAT_W     = 3;
  localparam int REC_W      = 5;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] CFG_BASE_ADDR   = 2'd1;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVER_CAP  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd5;

  // Level L occupies a fixed, size-aligned region of the free map:
  // it starts at 2*MAX_BLOCKS - (2*MAX_BLOCKS >> L).
  function automatic logic [MAP_AW-1:0] level_start(input logic [LVL_W-1:0] lv);
    logic [MAP_AW:0] full;
    full = (MAP_AW+1)'(2 * MAX_BLOCKS) - ((MAP_AW+1)'(2 * MAX_BLOCKS) >> lv);
    return full[MAP_AW-1:0];
  endfunction

endpackage

@@ sv/bba_ram.sv @@
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/buddy_block_allocator.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   kind, request_bytes, release_address
// rsp       out        rsp_valid/rsp_stall   status, granted_address, granted_level,
//                                            bytes_in_use
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One request is handled at a time; the free map is a 128 x 64-bit RAM read and then
// written back. An allocate checks the size, scans map words level by level and splits
// the found block down to the fit level; a free checks the address, reads the block record
// and merges with each free buddy; any other request goes straight to the response.
// Reset and each init clear both RAMs; init then seeds up to 13 levels, each odd-count one.
// The response sits in an output register, and a finished request waits only while a
// previous response is still stalled.
module buddy_block_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [1:0]                       kind,
  input  logic [bba_pkg::SIZE_W-1:0]       request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]       release_address,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [bba_pkg::STAT_W-1:0]       status,
  output logic [bba_pkg::ADDR_W-1:0]       granted_address,
  output logic [bba_pkg::LVL_W-1:0]        granted_level,
  output logic [bba_pkg::USED_W-1:0]       bytes_in_use,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]       cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLEAR     = 4'd1;
  localparam logic [3:0] S_SEED_SEL  = 4'd2;
  localparam logic [3:0] S_SEED_RD   = 4'd3;
  localparam logic [3:0] S_SEED_WR   = 4'd4;
  localparam logic [3:0] S_ALLOC     = 4'd5;
  localparam logic [3:0] S_SCAN_RD   = 4'd6;
  localparam logic [3:0] S_SCAN_CHK  = 4'd7;
  localparam logic [3:0] S_SPLIT     = 4'd8;
  localparam logic [3:0] S_SPLIT_RD  = 4'd9;
  localparam logic [3:0] S_SPLIT_WR  = 4'd10;
  localparam logic [3:0] S_FREE_CHK  = 4'd11;
  localparam logic [3:0] S_FREE_REC  = 4'd12;
  localparam logic [3:0] S_MERGE_RD  = 4'd13;
  localparam logic [3:0] S_MERGE_WR  = 4'd14;
  localparam logic [3:0] S_FINISH    = 4'd15;

  logic [3:0]                      state;
  logic                            seed_after;
  logic [bba_pkg::IDX_W-1:0]       clr_cnt;
  logic [bba_pkg::CNT_W-1:0]       reg_block_count;
  logic [bba_pkg::ADDR_W-1:0]      reg_base;
  logic [bba_pkg::CNT_W-1:0]       pool_blocks;
  logic [bba_pkg::ADDR_W-1:0]      pool_base;
  logic [bba_pkg::LVL_W-1:0]       level_limit;
  logic [bba_pkg::USED_W-1:0]      used;
  logic [bba_pkg::SIZE_W-1:0]      size_q;
  logic [bba_pkg::ADDR_W-1:0]      rel_addr_q;
  logic [bba_pkg::LVL_W-1:0]       lv;
  logic [bba_pkg::LVL_W-1:0]       fit;
  logic [bba_pkg::IDX_W-1:0]       off;
  logic [bba_pkg::IDX_W-1:0]       idx;
  logic [bba_pkg::WORD_AW-1:0]     scan_w;
  logic [bba_pkg::STAT_W-1:0]      res_status;
  logic [bba_pkg::ADDR_W-1:0]      res_addr;
  logic [bba_pkg::LVL_W-1:0]       res_level;

  // Map and record RAM ports.
  logic                            map_we;
  logic [bba_pkg::WORD_AW-1:0]     map_waddr;
  logic [bba_pkg::WORD_BITS-1:0]   map_wdata;
  logic [bba_pkg::WORD_AW-1:0]     map_raddr;
  logic [bba_pkg::WORD_BITS-1:0]   map_rdata;
  logic                            rec_we;
  logic [bba_pkg::IDX_W-1:0]       rec_waddr;
  logic [bba_pkg::REC_W-1:0]       rec_wdata;
  logic [bba_pkg::IDX_W-1:0]       rec_raddr;
  logic [bba_pkg::REC_W-1:0]       rec_rdata;

  // Derived values.
  logic [bba_pkg::CNT_W-1:0]       sat_blocks;
  logic [bba_pkg::LVL_W-1:0]       sat_limit;
  logic [bba_pkg::CNT_W-1:0]       nblk;
  logic [bba_pkg::MAP_AW-1:0]      lstart;
  logic [bba_pkg::MAP_AW-1:0]      gidx;
  logic [bba_pkg::WORD_BITS-1:0]   bit_oh;
  logic [bba_pkg::WORD_BITS-1:0]   buddy_oh;
  logic                            buddy_free;
  logic [bba_pkg::MAP_AW-1:0]      last_g;
  logic [bba_pkg::MAP_AW-1:0]      next_start;
  logic [bba_pkg::MAP_AW-1:0]      fit_start;
  logic [bba_pkg::WORD_BITS-1:0]   scan_mask;
  logic [bba_pkg::WORD_BITS-1:0]   hit_vec;
  logic [bba_pkg::WORD_SEL-1:0]    hit_bit;
  logic [bba_pkg::MAP_AW-1:0]      found_g;
  logic                            fits;
  logic [bba_pkg::LVL_W-1:0]       fit_c;
  logic [bba_pkg::USED_W-1:0]      bsize_c;
  logic [bba_pkg::USED_W-1:0]      bsize;
  logic [bba_pkg::ADDR_W-1:0]      rel;
  logic                            addr_bad;
  logic [bba_pkg::IDX_W-1:0]       first_blk;
  logic [bba_pkg::LVL_W-1:0]       rec_lv;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    sat_blocks = (reg_block_count > bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)) ?
                 bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) : reg_block_count;
    sat_limit = '0;
    for (int i = 0; i < bba_pkg::CNT_W; i++) begin
      if (sat_blocks[i]) begin
        sat_limit = bba_pkg::LVL_W'(i + 1);
      end
    end
  end

  assign nblk       = pool_blocks >> lv;
  assign lstart     = bba_pkg::level_start(lv);
  assign gidx       = lstart + {1'b0, off};
  assign bit_oh     = bba_pkg::WORD_BITS'(1) << gidx[bba_pkg::WORD_SEL-1:0];
  assign buddy_oh   = bba_pkg::WORD_BITS'(1) << (gidx[bba_pkg::WORD_SEL-1:0] ^ 6'd1);
  assign buddy_free = ({1'b0, off ^ 12'd1} < nblk) && ((map_rdata & buddy_oh) != '0);
  assign last_g     = lstart + nblk - bba_pkg::MAP_AW'(1);
  assign next_start = bba_pkg::level_start(lv + 4'd1);
  assign fit_start  = bba_pkg::level_start(fit_c);
  assign bsize      = bba_pkg::USED_W'(1) << (bba_pkg::MIN_SHIFT + int'(fit));
  assign first_blk  = off << fit;
  assign rec_lv     = rec_rdata[bba_pkg::LVL_W-1:0];

  // Bits of the current scan word that belong to the current level.
  always_comb begin
    for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin : mask_bits
      logic [bba_pkg::MAP_AW-1:0] g;
      logic [bba_pkg::MAP_AW-1:0] rel_b;
      g = {scan_w, bba_pkg::WORD_SEL'(b)};
      rel_b = g - lstart;
      scan_mask[b] = (g >= lstart) && (rel_b < nblk);
    end
  end

  assign hit_vec = scan_mask & map_rdata;

  always_comb begin
    hit_bit = '0;
    for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        hit_bit = bba_pkg::WORD_SEL'(b);
      end
    end
  end

  assign found_g = {scan_w, hit_bit};

  // Smallest usable level whose block holds the request.
  always_comb begin
    fits  = 1'b0;
    fit_c = '0;
    for (int l = bba_pkg::LEVELS - 1; l >= 0; l--) begin
      if ((bba_pkg::LVL_W'(l) < level_limit) &&
          ({1'b0, size_q} <= ((bba_pkg::SIZE_W+1)'(1) << (bba_pkg::MIN_SHIFT + l)))) begin
        fits  = 1'b1;
        fit_c = bba_pkg::LVL_W'(l);
      end
    end
  end

  assign bsize_c  = bba_pkg::USED_W'(1) << (bba_pkg::MIN_SHIFT + int'(fit_c));
  assign rel      = rel_addr_q - pool_base;
  assign addr_bad = (rel_addr_q == '0) || (rel_addr_q < pool_base) ||
                    (rel[bba_pkg::ADDR_W-1:bba_pkg::MIN_SHIFT] >=
                     (bba_pkg::ADDR_W - bba_pkg::MIN_SHIFT)'(pool_blocks));

  // RAM port steering.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = gidx[bba_pkg::MAP_AW-1:bba_pkg::WORD_SEL];
    map_wdata = map_rdata;
    map_raddr = gidx[bba_pkg::MAP_AW-1:bba_pkg::WORD_SEL];
    rec_we    = 1'b0;
    rec_waddr = idx;
    rec_wdata = '0;
    rec_raddr = rel[bba_pkg::MIN_SHIFT+bba_pkg::IDX_W-1:bba_pkg::MIN_SHIFT];
    unique case (state)
      S_CLEAR: begin
        map_we    = (clr_cnt < bba_pkg::IDX_W'(bba_pkg::WORD_DEPTH));
        map_waddr = clr_cnt[bba_pkg::WORD_AW-1:0];
        map_wdata = '0;
        rec_we    = 1'b1;
        rec_waddr = clr_cnt;
      end
      S_SEED_WR: begin
        map_we    = 1'b1;
        map_wdata = map_rdata | bit_oh;
      end
      S_SCAN_RD: begin
        map_raddr = scan_w;
      end
      S_SCAN_CHK: begin
        map_we    = (hit_vec != '0);
        map_waddr = scan_w;
        map_wdata = map_rdata & ~(bba_pkg::WORD_BITS'(1) << hit_bit);
      end
      S_SPLIT: begin
        rec_we    = (lv == fit);
        rec_waddr = first_blk;
        rec_wdata = {1'b1, fit};
      end
      S_SPLIT_WR: begin
        map_we    = 1'b1;
        map_wdata = (map_rdata & ~bit_oh) | buddy_oh;
      end
      S_FREE_REC: begin
        rec_we    = rec_rdata[bba_pkg::REC_W-1];
      end
      S_MERGE_WR: begin
        map_we    = 1'b1;
        map_wdata = buddy_free ? (map_rdata & ~bit_oh & ~buddy_oh) : (map_rdata | bit_oh);
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.WIDTH(bba_pkg::WORD_BITS), .DEPTH(bba_pkg::WORD_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::REC_W), .DEPTH(bba_pkg::MAX_BLOCKS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_block_count <= bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
      reg_base        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bba_pkg::CFG_BLOCK_COUNT) begin
        reg_block_count <= cfg_data[bba_pkg::CNT_W-1:0];
      end else if (cfg_index == bba_pkg::CFG_BASE_ADDR) begin
        reg_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      seed_after  <= 1'b0;
      clr_cnt     <= '0;
      pool_blocks <= bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
      pool_base   <= '0;
      level_limit <= bba_pkg::LVL_W'(bba_pkg::LEVELS);
      used        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // In the finish state the response register is handled below.
      if (rsp_valid && !rsp_stall && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            size_q     <= request_bytes;
            rel_addr_q <= release_address;
            res_status <= bba_pkg::ST_OK;
            res_addr   <= '0;
            res_level  <= '0;
            priority if (kind == bba_pkg::KIND_INIT) begin
              pool_blocks <= sat_blocks;
              pool_base   <= reg_base;
              level_limit <= sat_limit;
              used        <= '0;
              clr_cnt     <= '0;
              seed_after  <= 1'b1;
              state       <= S_CLEAR;
            end else if (kind == bba_pkg::KIND_ALLOC) begin
              state <= S_ALLOC;
            end else if (kind == bba_pkg::KIND_FREE) begin
              state <= S_FREE_CHK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            lv    <= '0;
            state <= seed_after ? S_SEED_SEL : S_IDLE;
          end
        end
        S_SEED_SEL: begin
          if (lv >= level_limit) begin
            state <= S_FINISH;
          end else if (nblk[0]) begin
            off   <= bba_pkg::IDX_W'(nblk - 1'b1);
            state <= S_SEED_RD;
          end else begin
            lv <= lv + 1'b1;
          end
        end
        S_SEED_RD: begin
          state <= S_SEED_WR;
        end
        S_SEED_WR: begin
          lv    <= lv + 1'b1;
          state <= S_SEED_SEL;
        end
        S_ALLOC: begin
          if (!fits) begin
            res_status <= bba_pkg::ST_TOO_LARGE;
            state      <= S_FINISH;
          end else if (({1'b0, used} + {1'b0, bsize_c}) >
                       {1'b0, pool_blocks, bba_pkg::MIN_SHIFT'(0)}) begin
            res_status <= bba_pkg::ST_OVER_CAP;
            state      <= S_FINISH;
          end else begin
            fit    <= fit_c;
            lv     <= fit_c;
            scan_w <= fit_start[bba_pkg::MAP_AW-1:bba_pkg::WORD_SEL];
            state  <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (hit_vec != '0) begin
            off   <= bba_pkg::IDX_W'(found_g - lstart);
            state <= S_SPLIT;
          end else if (scan_w != last_g[bba_pkg::MAP_AW-1:bba_pkg::WORD_SEL]) begin
            scan_w <= scan_w + 1'b1;
            state  <= S_SCAN_RD;
          end else if ((lv + 1'b1) < level_limit) begin
            lv     <= lv + 1'b1;
            scan_w <= next_start[bba_pkg::MAP_AW-1:bba_pkg::WORD_SEL];
            state  <= S_SCAN_RD;
          end else begin
            res_status <= bba_pkg::ST_NO_FREE;
            state      <= S_FINISH;
          end
        end
        S_SPLIT: begin
          if (lv > fit) begin
            lv    <= lv - 1'b1;
            off   <= off << 1;
            state <= S_SPLIT_RD;
          end else begin
            // The block record was written this cycle at the block's first index.
            used      <= used + bsize;
            res_addr  <= pool_base +
                         bba_pkg::ADDR_W'({first_blk, bba_pkg::MIN_SHIFT'(0)});
            res_level <= fit;
            state     <= S_FINISH;
          end
        end
        S_SPLIT_RD: begin
          state <= S_SPLIT_WR;
        end
        S_SPLIT_WR: begin
          state <= S_SPLIT;
        end
        S_FREE_CHK: begin
          if (addr_bad) begin
            res_status <= bba_pkg::ST_BAD_ADDR;
            state      <= S_FINISH;
          end else begin
            idx   <= rel[bba_pkg::MIN_SHIFT+bba_pkg::IDX_W-1:bba_pkg::MIN_SHIFT];
            state <= S_FREE_REC;
          end
        end
        S_FREE_REC: begin
          if (!rec_rdata[bba_pkg::REC_W-1]) begin
            res_status <= bba_pkg::ST_NOT_ALLOC;
            state      <= S_FINISH;
          end else begin
            lv        <= rec_lv;
            fit       <= rec_lv;
            off       <= idx >> rec_lv;
            res_level <= rec_lv;
            state     <= S_MERGE_RD;
          end
        end
        S_MERGE_RD: begin
          state <= S_MERGE_WR;
        end
        S_MERGE_WR: begin
          if (buddy_free && ((lv + 1'b1) < level_limit)) begin
            lv    <= lv + 1'b1;
            off   <= off >> 1;
            state <= S_MERGE_RD;
          end else begin
            used  <= (used >= bsize) ? (used - bsize) : '0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!(rsp_valid && rsp_stall)) begin
            rsp_valid       <= 1'b1;
            status          <= res_status;
            granted_address <= res_addr;
            granted_level   <= res_level;
            bytes_in_use    <= used;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_map_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !map_we)
    else $error("free map written while idle");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("response raised outside finish");

  a_scan_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_RD || state == S_MERGE_RD) |-> (lv < level_limit))
    else $error("level walk passed the level limit");

  a_split_above_fit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT_WR) |-> (lv >= fit))
    else $error("split went below the fit level");
`endif

endmodule
